FILE: src/bbpq_pkg.sv
// Package for the byte-budgeted packet descriptor queue: operation codes,
// field widths, the descriptor layout and reset constants.
// No dependencies; used by byte_budget_packet_queue.
`timescale 1ns / 1ps
`default_nettype none

package bbpq_pkg;

   localparam int QUEUE_DEPTH = 64;

   localparam int ADDR_W  = 32;
   localparam int PORT_W  = 16;
   localparam int SIZE_W  = 16;
   localparam int TOTAL_W = 23;
   localparam int LIMIT_W = 20;
   localparam int COUNT_W = 7;
   localparam int DROPS_W = 6;
   localparam int DCNT_W  = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd64000;

   // Request tdata is 64 bits, response tdata 132 bits padded to 136.
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 136;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_POP     = 2'd1,
      OP_FLUSH   = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [PORT_W-1:0] port;
      logic [SIZE_W-1:0] size;
   } entry_type;

endpackage

`default_nettype wire

FILE: src/byte_budget_packet_queue.sv
// Top level of the byte-budgeted packet descriptor queue: request sequencer,
// descriptor memory with forwarding, configuration register and response register.
// Depends on bbpq_pkg.
//
// Usage. Requests arrive on the req_ stream: tuser carries the operation
// (enqueue, pop head, flush, clear drop counter), tdata the descriptor to
// enqueue. Each request yields exactly one response on the rsp_ stream with
// the queue state after the operation: the head descriptor, the byte total,
// the entry count, the drops caused by this request and the drop counter.
// Pop, flush and clear complete in the cycle they are accepted, so their response
// is registered and appears in the next cycle. An enqueue first drops entries as
// needed, then writes the new entry once the response register is free. The drop
// loop reads the size of the second-oldest entry from the descriptor memory's
// registered read port; the read for the next drop is issued in the same cycle as
// the current one retires. The head descriptor is held in a register, so a drop
// only moves the head pointer and never rewrites memory. Reset empties the queue,
// clears the drop counter and loads the byte limit with 64000; the memory needs no
// clearing pass, as only written entries are ever read. When the receiver stalls,
// the response waits in its register; a request is taken only once that register
// is free or being drained. The byte limit is to be written over the csr_ port
// while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module byte_budget_packet_queue #(
   parameter int QUEUE_DEPTH = bbpq_pkg::QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: dest_address[31:0], dest_port[47:32], packet_size[63:48]
   input  wire logic [bbpq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: op[1:0]
   input  wire logic [1:0]                        req_tuser,
   // Response stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: head_address[31:0], head_port[47:32], head_size[63:48],
   // total_bytes[86:64], entry_count[93:87], drops_now[99:94],
   // drop_total[131:100], zero padding[135:132]
   output logic [bbpq_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // tuser: head_valid[0]
   output logic                                   rsp_tuser,
   // Configuration port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [2:0]                        csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   localparam int PW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int TW = bbpq_pkg::TOTAL_W;
   localparam int LW = bbpq_pkg::LIMIT_W;
   localparam int SW = bbpq_pkg::SIZE_W;
   localparam int NW = bbpq_pkg::COUNT_W;
   localparam int DW = bbpq_pkg::DROPS_W;
   localparam int KW = bbpq_pkg::DCNT_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_ENQ  = 2'b10
   } state_type;

   // Sequencer and queue state.
   state_type             state_ff, state_in;
   logic [PW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [TW-1:0]         total_ff, total_in;
   logic [KW-1:0]         dcnt_ff, dcnt_in;
   logic [DW-1:0]         drops_ff, drops_in;
   logic [LW-1:0]         limit_ff, limit_in;
   bbpq_pkg::entry_type   head_ent_ff, head_ent_in;
   bbpq_pkg::entry_type   new_ff, new_in;

   // Response register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bbpq_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                              rsp_user_ff, rsp_user_in;

   // Descriptor memory with a registered read port and write forwarding.
   bbpq_pkg::entry_type   mem [QUEUE_DEPTH];
   bbpq_pkg::entry_type   rd_q_ff;
   bbpq_pkg::entry_type   fwd_data_ff;
   logic                  fwd_hit_ff;
   bbpq_pkg::entry_type   rd_eff;
   logic [PW-1:0]         rd_addr;
   logic                  wr_en;
   logic [PW-1:0]         wr_addr;
   bbpq_pkg::entry_type   wr_data;
   logic [CW:0]           wr_sum;

   logic                  req_go;
   logic                  out_free;
   logic                  done;
   logic                  drop_cond;
   logic                  drop_go;
   logic                  csr_wr;
   logic [CW+NW-1:0]      count_ext;
   logic [NW-1:0]         count_sat;
   bbpq_pkg::entry_type   head_out;

   function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(p + PW'(1));
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_go     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Register 0 lies at byte address 0; bit 2 of the address selects
   // anything beyond it, which reads as zero and ignores writes.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(limit_ff);
   assign limit_in   = (csr_wr && !csr_paddr[2]) ? csr_pwdata[LW-1:0] : limit_ff;

   // The memory always holds a read of the slot after the head, so the
   // entry that a pop promotes or a drop removes is ready without delay.
   assign rd_eff  = fwd_hit_ff ? fwd_data_ff : rd_q_ff;
   assign rd_addr = next_slot(head_in);

   // The tail slot is head plus count, wrapped once.
   assign wr_sum  = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign wr_addr = (wr_sum >= (CW + 1)'(QUEUE_DEPTH))
                    ? PW'(wr_sum - (CW + 1)'(QUEUE_DEPTH)) : PW'(wr_sum);
   assign wr_data = new_ff;

   // Drop the second-oldest entry while the budget would be reached or the
   // store is full; the head is never dropped.
   assign drop_cond = (count_ff >= CW'(2)) &&
                      (((TW + 1)'(total_ff) + (TW + 1)'(new_ff.size)
                           >= (TW + 1)'(limit_ff)) ||
                       (count_ff >= CW'(QUEUE_DEPTH)));

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      dcnt_in     = dcnt_ff;
      drops_in    = drops_ff;
      head_ent_in = head_ent_ff;
      new_in      = new_ff;
      wr_en       = 1'b0;
      done        = 1'b0;
      drop_go     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_go) begin
               drops_in = '0;
               case (bbpq_pkg::op_type'(req_tuser))
                  bbpq_pkg::OP_ENQUEUE: begin
                     new_in.addr = req_tdata[31:0];
                     new_in.port = req_tdata[47:32];
                     new_in.size = req_tdata[63:48];
                     state_in    = S_ENQ;
                  end
                  bbpq_pkg::OP_POP: begin
                     if (count_ff != '0) begin
                        total_in    = TW'(total_ff - TW'(head_ent_ff.size));
                        head_in     = next_slot(head_ff);
                        count_in    = CW'(count_ff - CW'(1));
                        head_ent_in = rd_eff;
                     end
                     done = 1'b1;
                  end
                  bbpq_pkg::OP_FLUSH: begin
                     count_in = '0;
                     total_in = '0;
                     head_in  = '0;
                     done     = 1'b1;
                  end
                  default: begin
                     dcnt_in = '0;
                     done    = 1'b1;
                  end
               endcase
            end
         end
         S_ENQ: begin
            if (drop_cond) begin
               drop_go  = 1'b1;
               total_in = TW'(total_ff - TW'(rd_eff.size));
               head_in  = next_slot(head_ff);
               count_in = CW'(count_ff - CW'(1));
               dcnt_in  = KW'(dcnt_ff + KW'(1));
               drops_in = (drops_ff == '1) ? drops_ff : DW'(drops_ff + DW'(1));
            end else if (out_free) begin
               wr_en    = 1'b1;
               count_in = CW'(count_ff + CW'(1));
               total_in = TW'(total_ff + TW'(new_ff.size));
               if (count_ff == '0) begin
                  head_ent_in = new_ff;
               end
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response built from the state after the request.
   assign count_ext = (CW + NW)'(count_in);
   assign count_sat = (count_ext > (CW + NW)'(127)) ? NW'(127) : count_ext[NW-1:0];
   assign head_out  = (count_in != '0) ? head_ent_in : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = (count_in != '0);
         rsp_data_in  = {4'd0, dcnt_in, drops_in, count_sat, total_in,
                         head_out.size, head_out.port, head_out.addr};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         dcnt_ff      <= '0;
         drops_ff     <= '0;
         limit_ff     <= bbpq_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         dcnt_ff      <= dcnt_in;
         drops_ff     <= drops_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_hit_ff   <= wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      head_ent_ff <= head_ent_in;
      new_ff      <= new_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // The queue never holds more entries than the store has slots.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   // The head pointer stays inside the store.
   assert property (@(posedge clock) disable iff (reset)
      head_ff <= PW'(QUEUE_DEPTH - 1))
      else $error("head pointer out of range");

   // An empty queue buffers no bytes.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (total_ff == '0))
      else $error("byte total non-zero with empty queue");

   // Each drop removes exactly one entry and counts once.
   assert property (@(posedge clock) disable iff (reset)
      drop_go |=> (count_ff == CW'($past(count_ff) - CW'(1))) &&
                  (dcnt_ff == KW'($past(dcnt_ff) + KW'(1))))
      else $error("drop did not retire exactly one entry");

   // A drop only happens with at least two entries, so the head survives.
   assert property (@(posedge clock) disable iff (reset)
      drop_go |=> (count_ff != '0) && (head_ent_ff == $past(head_ent_ff)))
      else $error("drop disturbed the head entry");

endmodule

`default_nettype wire

FILE: test/tb_byte_budget_packet_queue.sv
// Self-checking testbench for the byte-budgeted packet descriptor queue:
// a directed table of requests, then random phases under several byte limits.
// Depends on bbpq_pkg and byte_budget_packet_queue.
`timescale 1ns / 1ps

module tb_byte_budget_packet_queue;
   import bbpq_pkg::*;

   // The byte limit is the only register, so it sits at byte address 0.
   localparam logic [2:0] LIMIT_ADDR = 3'd0;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = 20'hF_FFFF;
   // Generous bound on the whole run, far above the slowest correct run.
   localparam int RUN_LIMIT_NS = 12_000_000;
   // Longest receiver hold-off used to back the block up.
   localparam int LONG_HOLD = 90;
   // Only this many mismatches are printed; all of them are counted.
   localparam int REPORT_CAP = 100;

   // Queue state as seen on one response, in the order of the tdata fields.
   typedef struct packed {
      logic               head_valid;
      logic [ADDR_W-1:0]  head_address;
      logic [PORT_W-1:0]  head_port;
      logic [SIZE_W-1:0]  head_size;
      logic [TOTAL_W-1:0] total_bytes;
      logic [COUNT_W-1:0] entry_count;
      logic [DROPS_W-1:0] drops_now;
      logic [DCNT_W-1:0]  drop_total;
   } queue_status;

   typedef enum logic {
      ROW_REQUEST,
      ROW_LIMIT
   } row_kind;

   // One line of the directed table: either a request or a new byte limit.
   // Where typed is set, want holds the status worked out by hand.
   typedef struct {
      row_kind           kind;
      op_type            op;
      entry_type         item;
      logic              typed;
      queue_status       want;
      logic [LIMIT_W-1:0] limit;
   } stim_row;

   typedef enum logic [1:0] {
      STALL_NEVER,
      STALL_EVERY_FOURTH,
      STALL_COIN,
      STALL_SELDOM
   } stall_mode;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = OP_POP;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [2:0]            csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   byte_budget_packet_queue u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // If anything hangs, the run is stopped here and counts as failed.
   initial begin
      #(RUN_LIMIT_NS);
      $display("byte_budget_packet_queue: mismatch");
      $finish;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the queue. It is advanced once for every request the
   // block accepts, in acceptance order, and the status it produces is
   // queued up for the response checker.
   // ------------------------------------------------------------------
   entry_type          shadow_slots [QUEUE_DEPTH];
   int unsigned        shadow_head;
   int unsigned        shadow_count;
   int unsigned        shadow_bytes;
   logic [DCNT_W-1:0]  shadow_drops;
   logic [LIMIT_W-1:0] shadow_limit;

   queue_status due_status [$];
   int          mismatches = 0;
   int          burst_left = 0;
   int          hold_ticket = 0;

   // Applies one request to the shadow queue and returns the status the
   // block should report afterwards.
   function automatic queue_status predict_status(input op_type op, input entry_type item);
      queue_status status;
      int unsigned dropped;
      int unsigned second;
      dropped = 0;
      case (op)
         OP_ENQUEUE: begin
            // The head may be on the wire, so the second-oldest entry goes
            // first; the head slides up into its slot each time.
            while (shadow_count >= 2 &&
                   (shadow_bytes + item.size >= shadow_limit ||
                    shadow_count >= QUEUE_DEPTH)) begin
               second = (shadow_head + 1) % QUEUE_DEPTH;
               shadow_bytes = shadow_bytes - shadow_slots[second].size;
               shadow_slots[second] = shadow_slots[shadow_head];
               shadow_head = second;
               shadow_count--;
               shadow_drops++;
               dropped++;
            end
            shadow_slots[(shadow_head + shadow_count) % QUEUE_DEPTH] = item;
            shadow_count++;
            shadow_bytes = shadow_bytes + item.size;
         end
         OP_POP: begin
            if (shadow_count > 0) begin
               shadow_bytes = shadow_bytes - shadow_slots[shadow_head].size;
               shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
               shadow_count--;
            end
         end
         OP_FLUSH: begin
            shadow_count = 0;
            shadow_bytes = 0;
            shadow_head = 0;
         end
         default: begin
            shadow_drops = '0;
         end
      endcase
      status = '0;
      if (shadow_count > 0) begin
         status.head_valid   = 1'b1;
         status.head_address = shadow_slots[shadow_head].addr;
         status.head_port    = shadow_slots[shadow_head].port;
         status.head_size    = shadow_slots[shadow_head].size;
      end
      status.total_bytes = shadow_bytes[TOTAL_W-1:0];
      status.entry_count = (shadow_count > 127) ? 7'd127 : shadow_count[COUNT_W-1:0];
      status.drops_now   = (dropped > 63) ? 6'd63 : dropped[DROPS_W-1:0];
      status.drop_total  = shadow_drops;
      return status;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_CAP)
            $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side. Every response must match the oldest outstanding
   // status; a response with nothing outstanding is a failure too.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_responses
      queue_status seen;
      queue_status want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.head_valid   = rsp_tuser;
         seen.head_address = rsp_tdata[31:0];
         seen.head_port    = rsp_tdata[47:32];
         seen.head_size    = rsp_tdata[63:48];
         seen.total_bytes  = rsp_tdata[86:64];
         seen.entry_count  = rsp_tdata[93:87];
         seen.drops_now    = rsp_tdata[99:94];
         seen.drop_total   = rsp_tdata[131:100];
         if (due_status.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("%0t ns: response expected none, got %h", $time, seen);
         end else begin
            want = due_status.pop_front();
            compare_field("head_valid", want.head_valid, seen.head_valid);
            compare_field("head_address", want.head_address, seen.head_address);
            compare_field("head_port", want.head_port, seen.head_port);
            compare_field("head_size", want.head_size, seen.head_size);
            compare_field("total_bytes", want.total_bytes, seen.total_bytes);
            compare_field("entry_count", want.entry_count, seen.entry_count);
            compare_field("drops_now", want.drops_now, seen.drops_now);
            compare_field("drop_total", want.drop_total, seen.drop_total);
         end
      end
   end

   // The receiver wanders between stall patterns of its own. When the
   // stimulus raises hold_ticket it refuses every response until a countdown
   // from LONG_HOLD has run out, so that the single response register backs up
   // and the block has to hold off further requests.
   int        hold_served = 0;
   int        hold_left = 0;
   int        mode_left = 0;
   stall_mode mode = STALL_NEVER;
   logic [1:0] stall_tick = '0;

   always @(posedge clock) begin
      if (hold_ticket != hold_served) begin
         hold_served <= hold_ticket;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall_tick <= stall_tick + 2'd1;
         if (mode_left == 0) begin
            mode_left <= $urandom_range(40, 160);
            case ($urandom_range(0, 3))
               0: mode <= STALL_NEVER;
               1: mode <= STALL_EVERY_FOURTH;
               2: mode <= STALL_COIN;
               default: mode <= STALL_SELDOM;
            endcase
         end else begin
            mode_left <= mode_left - 1;
         end
         case (mode)
            STALL_NEVER:        rsp_tready <= 1'b1;
            STALL_EVERY_FOURTH: rsp_tready <= (stall_tick != 2'b11);
            STALL_COIN:         rsp_tready <= $urandom_range(0, 1);
            default:            rsp_tready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Request side. All drives are nonblocking and happen just after a
   // rising edge; req_tvalid is left high between back-to-back requests
   // and lowered only when a gap or a pause follows.
   // ------------------------------------------------------------------
   task automatic send_request(input op_type op, input entry_type item,
                               input logic typed, input queue_status want);
      queue_status predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {item.size, item.port, item.addr};
      do @(posedge clock); while (!req_tready);
      predicted = predict_status(op, item);
      due_status.push_back(typed ? want : predicted);
   endtask

   // Bursts of random length, optionally separated by short gaps.
   task automatic pace(input logic with_gaps);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 11);
         if (with_gaps) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // Stops offering requests until every response has been taken. Every
   // request yields a response, so the block is idle once this returns.
   task automatic wait_until_settled();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (due_status.size() != 0);
   endtask

   // One register access: a setup phase, then an access phase that ends
   // at the edge where pready is seen high.
   task automatic csr_access(input logic write, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Writes a new byte limit once the queue has gone quiet, then reads it back.
   task automatic set_limit(input logic [LIMIT_W-1:0] value);
      logic [31:0] readback;
      wait_until_settled();
      csr_access(1'b1, LIMIT_ADDR, {12'd0, value}, readback);
      shadow_limit = value;
      csr_access(1'b0, LIMIT_ADDR, '0, readback);
      compare_field("byte_limit", {12'd0, value}, readback);
   endtask

   function automatic stim_row request_row(input op_type op, input logic [31:0] addr,
                                           input logic [15:0] port, input logic [15:0] size,
                                           input logic typed, input queue_status want);
      stim_row row;
      row.kind  = ROW_REQUEST;
      row.op    = op;
      row.item  = '{addr: addr, port: port, size: size};
      row.typed = typed;
      row.want  = want;
      row.limit = '0;
      return row;
   endfunction

   function automatic stim_row limit_row(input logic [LIMIT_W-1:0] value);
      stim_row row;
      row = request_row(OP_POP, '0, '0, '0, 1'b0, '0);
      row.kind  = ROW_LIMIT;
      row.limit = value;
      return row;
   endfunction

   // A random request. Sizes mostly stay below size_cap so that the queue
   // can grow; now and then a size from the whole range or an extreme.
   task automatic random_request(input int enq_percent, input int size_cap,
                                 output op_type op, output entry_type item);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < enq_percent)
         op = OP_ENQUEUE;
      else if (pick < enq_percent + (100 - enq_percent) * 6 / 10)
         op = OP_POP;
      else if (pick < enq_percent + (100 - enq_percent) * 8 / 10)
         op = OP_FLUSH;
      else
         op = OP_CLEAR;
      item.addr = $urandom;
      item.port = $urandom_range(0, 65535);
      case ($urandom_range(0, 15))
         0:       item.size = '0;
         1:       item.size = 16'hFFFF;
         2, 3:    item.size = $urandom_range(0, 65535);
         default: item.size = $urandom_range(0, size_cap);
      endcase
   endtask

   // A run of random requests; pause_at, if not negative, is the request
   // after which the sender waits for every outstanding response.
   task automatic run_phase(input int requests, input int enq_percent, input int size_cap,
                            input logic with_gaps, input int pause_at);
      op_type    op;
      entry_type item;
      for (int n = 0; n < requests; n++) begin
         random_request(enq_percent, size_cap, op, item);
         send_request(op, item, 1'b0, '0);
         if (n == pause_at)
            wait_until_settled();
         else
            pace(with_gaps);
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      stim_row     rows [$];
      logic [31:0] readback;
      entry_type   item;

      shadow_head  = 0;
      shadow_count = 0;
      shadow_bytes = 0;
      shadow_drops = '0;
      shadow_limit = LIMIT_RESET;
      foreach (shadow_slots[i]) shadow_slots[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The byte limit must come out of reset at its default.
      csr_access(1'b0, LIMIT_ADDR, '0, readback);
      compare_field("byte_limit", {12'd0, LIMIT_RESET}, readback);

      // Directed part. The first rows start from an empty queue with the
      // default limit, so their status can be worked out by hand.
      // Pop, clear and flush on an empty queue leave everything at zero.
      rows.push_back(request_row(OP_POP, 32'h0, 16'h0, 16'h0, 1'b1, '0));
      rows.push_back(request_row(OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, '0));
      rows.push_back(request_row(OP_FLUSH, 32'h0, 16'h0, 16'h0, 1'b1, '0));
      // A lone entry above the budget is still taken: there is nothing
      // that could be dropped, since the head is never touched.
      rows.push_back(request_row(OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1,
         '{1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 23'd65535, 7'd1, 6'd0, 32'd0}));
      rows.push_back(request_row(OP_ENQUEUE, 32'h0, 16'h0, 16'h0, 1'b1,
         '{1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 23'd65535, 7'd2, 6'd0, 32'd0}));
      // Now the budget is reached with two entries queued: the zero-sized
      // second entry goes, the head stays.
      rows.push_back(request_row(OP_ENQUEUE, 32'h1234_5678, 16'h0050, 16'h0064, 1'b1,
         '{1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 23'd65635, 7'd2, 6'd1, 32'd1}));
      rows.push_back(request_row(OP_POP, 32'h0, 16'h0, 16'h0, 1'b0, '0));
      rows.push_back(request_row(OP_ENQUEUE, 32'hA5A5_5A5A, 16'h1F90, 16'h8000, 1'b0, '0));
      rows.push_back(request_row(OP_ENQUEUE, 32'h0F0F_F0F0, 16'h0001, 16'h0000, 1'b0, '0));
      rows.push_back(request_row(OP_POP, 32'h0, 16'h0, 16'h0, 1'b0, '0));
      // Flush empties the queue but keeps the drop counter.
      rows.push_back(request_row(OP_FLUSH, 32'h0, 16'h0, 16'h0, 1'b1,
         '{1'b0, 32'h0, 16'h0, 16'h0, 23'd0, 7'd0, 6'd0, 32'd1}));
      rows.push_back(request_row(OP_CLEAR, 32'h0, 16'h0, 16'h0, 1'b1, '0));
      rows.push_back(request_row(OP_ENQUEUE, 32'h0000_0001, 16'h8000, 16'h0001, 1'b1,
         '{1'b1, 32'h0000_0001, 16'h8000, 16'h0001, 23'd1, 7'd1, 6'd0, 32'd0}));
      rows.push_back(request_row(OP_POP, 32'h0, 16'h0, 16'h0, 1'b1, '0));
      rows.push_back(request_row(OP_POP, 32'h0, 16'h0, 16'h0, 1'b1, '0));
      // With a limit of zero every enqueue cuts the queue back to its head.
      rows.push_back(limit_row('0));
      rows.push_back(request_row(OP_ENQUEUE, 32'hFFFF_0000, 16'h0000, 16'hFFFF, 1'b0, '0));
      rows.push_back(request_row(OP_ENQUEUE, 32'h0000_FFFF, 16'hFFFF, 16'h0000, 1'b0, '0));
      rows.push_back(request_row(OP_ENQUEUE, 32'h5555_AAAA, 16'hAAAA, 16'h5555, 1'b0, '0));
      rows.push_back(request_row(OP_ENQUEUE, 32'hAAAA_5555, 16'h5555, 16'hAAAA, 1'b0, '0));
      rows.push_back(limit_row(LIMIT_MAX));
      rows.push_back(request_row(OP_ENQUEUE, 32'h8000_0001, 16'h7FFE, 16'h7FFF, 1'b0, '0));
      rows.push_back(request_row(OP_ENQUEUE, 32'h7FFF_FFFE, 16'h8001, 16'h8000, 1'b0, '0));
      rows.push_back(request_row(OP_POP, 32'h0, 16'h0, 16'h0, 1'b0, '0));
      rows.push_back(limit_row(LIMIT_RESET));
      rows.push_back(request_row(OP_FLUSH, 32'h0, 16'h0, 16'h0, 1'b0, '0));

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_LIMIT) begin
            set_limit(rows[i].limit);
         end else begin
            send_request(rows[i].op, rows[i].item, rows[i].typed, rows[i].want);
            pace(1'b1);
         end
      end

      // Random part, one byte limit per phase.
      // A tight budget: drops on almost every enqueue.
      set_limit($urandom_range(1, 5000));
      run_phase(80, 55, 1500, 1'b1, -1);

      // The widest budget with enqueues dominating, so that the store
      // fills up and drops are forced by the depth as well as the bytes.
      set_limit(LIMIT_MAX);
      run_phase(120, 80, 30000, 1'b1, -1);

      // Fill the store to the brim with small descriptors, then drop the
      // limit to zero: the next enqueue has to throw away all but the head.
      wait_until_settled();
      send_request(OP_FLUSH, '0, 1'b0, '0);
      for (int n = 0; n < QUEUE_DEPTH + 2; n++) begin
         item.addr = $urandom;
         item.port = $urandom_range(0, 65535);
         item.size = $urandom_range(0, 200);
         send_request(OP_ENQUEUE, item, 1'b0, '0);
         pace(1'b1);
      end
      set_limit('0);
      run_phase(6, 100, 65535, 1'b1, -1);

      // A budget of one byte, sent back to back with no gaps.
      set_limit(20'd1);
      run_phase(60, 60, 3000, 1'b0, -1);

      // Default budget under back-pressure: the receiver holds off for a
      // long stretch while requests keep coming without gaps; halfway
      // through, the sender waits for every response before going on.
      set_limit(LIMIT_RESET);
      hold_ticket <= hold_ticket + 1;
      run_phase(100, 65, 65535, 1'b0, 50);

      // Any budget at all; sizes mostly up to 20000, now and then from the full range.
      set_limit($urandom_range(0, 1048575));
      run_phase(100, 60, 20000, 1'b1, -1);

      // Let the last responses drain, then allow for the longest enqueue
      // in case anything unexpected is still on its way.
      wait_until_settled();
      repeat (QUEUE_DEPTH + 16) @(posedge clock);
      if (due_status.size() != 0) begin
         mismatches++;
         $display("%0t ns: outstanding responses expected 0, got %0d", $time,
                  due_status.size());
      end

      if (mismatches == 0)
         $display("byte_budget_packet_queue: match");
      else
         $display("byte_budget_packet_queue: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
src/bbpq_pkg.sv
src/byte_budget_packet_queue.sv
test/tb_byte_budget_packet_queue.sv
